FILE: hdl/jnc_pkg.sv
// Package: opcodes, result kinds and the decoded operation class of the numeric conversion unit.
package jnc_pkg;
	localparam logic [7:0] OP_I2L = 8'h85;
	localparam logic [7:0] OP_I2F = 8'h86;
	localparam logic [7:0] OP_I2D = 8'h87;
	localparam logic [7:0] OP_I2B = 8'h91;
	localparam logic [7:0] OP_I2C = 8'h92;
	localparam logic [7:0] OP_I2S = 8'h93;
	localparam logic [7:0] OP_D2F = 8'h90;
	localparam logic [7:0] OP_D2I = 8'h8e;
	localparam logic [7:0] OP_D2L = 8'h8f;

	typedef enum logic [1:0] {
		KIND_INT    = 2'd0,
		KIND_LONG   = 2'd1,
		KIND_FLOAT  = 2'd2,
		KIND_DOUBLE = 2'd3
	} kind_t;

	// decoded operation class carried down the pipe
	typedef enum logic [3:0] {
		CLS_I2L, CLS_I2F, CLS_I2D, CLS_I2B, CLS_I2C, CLS_I2S,
		CLS_D2F, CLS_D2I, CLS_D2L, CLS_BAD
	} cls_t;
endpackage

FILE: hdl/jvm_numeric_conversion_unit.sv
// Top level: four-stage pipelined JVM int/long/float/double conversion unit.
// A word enters every cycle when the output side keeps up. There are four
// register stages (decode, normalise/align, round, pack), and a word moves
// through them in that order into the output register. The pipe advances as
// a whole whenever the output register is empty or being taken, and holds
// every stage while the output is stalled.
// Input ready is high whenever the pipe can advance, so back-to-back words
// flow at one per cycle when not stalled. Results follow JVM rules: round to
// nearest even for i2f/d2f, truncation with saturation for d2i/d2l, NaN to zero.
module jvm_numeric_conversion_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  operation,
	input  logic [63:0] operand,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result,
	output logic [1:0]  result_kind,
	output logic        unsupported
);
	import jnc_pkg::*;

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// ---------------- stage 1: decode, magnitude, field split
	logic        v_s1;
	cls_t        cls_s1;
	logic        sgn_s1;
	logic [31:0] iv_s1;
	logic [31:0] mag_s1;
	logic [10:0] exp_s1;
	logic [51:0] frac_s1;
	cls_t        cls_d;

	always_comb begin
		case (operation)
			OP_I2L:  cls_d = CLS_I2L;
			OP_I2F:  cls_d = CLS_I2F;
			OP_I2D:  cls_d = CLS_I2D;
			OP_I2B:  cls_d = CLS_I2B;
			OP_I2C:  cls_d = CLS_I2C;
			OP_I2S:  cls_d = CLS_I2S;
			OP_D2F:  cls_d = CLS_D2F;
			OP_D2I:  cls_d = CLS_D2I;
			OP_D2L:  cls_d = CLS_D2L;
			default: cls_d = CLS_BAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s1  <= cls_d;
			iv_s1   <= operand[31:0];
			sgn_s1  <= (cls_d == CLS_D2F || cls_d == CLS_D2I || cls_d == CLS_D2L)
				? operand[63] : operand[31];
			mag_s1  <= operand[31] ? (32'd0 - operand[31:0]) : operand[31:0];
			exp_s1  <= operand[62:52];
			frac_s1 <= operand[51:0];
		end
	end

	// ---------------- stage 2: leading one / normalise ints, align doubles
	logic [4:0]  lz_c;
	logic [31:0] nrm_c;
	logic        found;
	always_comb begin
		lz_c  = 5'd0;
		found = 1'b0;
		for (int i = 31; i >= 0; i--) begin
			if (!found && mag_s1[i]) begin
				lz_c  = 5'(31 - i);
				found = 1'b1;
			end
		end
		nrm_c = mag_s1 << lz_c;
	end

	// double side: d2f shift amount and d2i/d2l alignment
	logic signed [12:0] ee_c;
	logic [52:0]        m_c;
	logic [6:0]         sh_c;
	logic [115:0]       al_c;   // mantissa placed so integer part sits in [115:52]
	always_comb begin
		ee_c = $signed({2'b00, exp_s1}) - 13'sd1023;
		m_c  = {1'b1, frac_s1};
		// d2f subnormal path right shift: 29 + (-126 - E), clipped at 63
		if (ee_c >= -13'sd126)
			sh_c = 7'd29;
		else if (ee_c < -13'sd160)
			sh_c = 7'd63;
		else
			sh_c = 7'(13'sd29 - 13'sd126 - ee_c);
		// integer alignment: value = m * 2^(E-52); binary point sits below bit 52
		if (ee_c >= 13'sd0 && ee_c <= 13'sd63)
			al_c = {63'd0, m_c} << ee_c[5:0];
		else
			al_c = '0;
	end

	logic        v_s2;
	cls_t        cls_s2;
	logic        sgn_s2;
	logic [31:0] iv_s2;
	logic [31:0] nrm_s2;
	logic [4:0]  lz_s2;
	logic        izero_s2;
	logic [10:0] exp_s2;
	logic [51:0] frac_s2;
	logic signed [12:0] ee_s2;
	logic [6:0]  sh_s2;
	logic [63:0] ipart_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s2   <= cls_s1;
			sgn_s2   <= sgn_s1;
			iv_s2    <= iv_s1;
			nrm_s2   <= nrm_c;
			lz_s2    <= lz_c;
			izero_s2 <= (mag_s1 == 32'd0);
			exp_s2   <= exp_s1;
			frac_s2  <= frac_s1;
			ee_s2    <= ee_c;
			sh_s2    <= sh_c;
			ipart_s2 <= al_c[115:52];
		end
	end

	// ---------------- stage 3: rounding
	// i2f: 24-bit significand from normalised word, round on low 8 bits
	logic [24:0] fk_c;
	logic        frnd;
	always_comb begin
		frnd = nrm_s2[7] && ((nrm_s2[6:0] != 7'd0) || nrm_s2[8]);
		fk_c = {1'b0, nrm_s2[31:8]} + {24'd0, frnd};
	end

	// d2f: shift mantissa right by sh with round to nearest even
	logic [52:0]  dm_c;
	logic [116:0] dsh_c;
	logic [53:0]  dkeep_c;
	logic         dhalf, dsticky, drnd;
	logic [53:0]  dk_c;
	always_comb begin
		dm_c    = {1'b1, frac_s2};
		dsh_c   = {dm_c, 64'd0} >> sh_s2;
		dkeep_c = {1'b0, dsh_c[116:64]};
		dhalf   = dsh_c[63];
		dsticky = dsh_c[62:0] != 63'd0;
		drnd    = dhalf && (dsticky || dkeep_c[0]);
		dk_c    = dkeep_c + {53'd0, drnd};
	end

	// d2i/d2l saturation decisions
	logic        nan_c, ovf32_c, ovf64_c, tiny_c;
	always_comb begin
		nan_c   = (exp_s2 == 11'h7ff) && (frac_s2 != 52'd0);
		tiny_c  = (exp_s2 == 11'd0) || (ee_s2 < 13'sd0);
		ovf32_c = ee_s2 >= 13'sd31;
		ovf64_c = ee_s2 >= 13'sd63;
	end

	logic        v_s3;
	cls_t        cls_s3;
	logic        sgn_s3;
	logic [31:0] iv_s3;
	logic [31:0] nrm_s3;
	logic [4:0]  lz_s3;
	logic        izero_s3;
	logic [10:0] exp_s3;
	logic [51:0] frac_s3;
	logic signed [12:0] ee_s3;
	logic [24:0] fk_s3;
	logic [53:0] dk_s3;
	logic [63:0] ipart_s3;
	logic        nan_s3, tiny_s3, ovf32_s3, ovf64_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s3   <= cls_s2;
			sgn_s3   <= sgn_s2;
			iv_s3    <= iv_s2;
			nrm_s3   <= nrm_s2;
			lz_s3    <= lz_s2;
			izero_s3 <= izero_s2;
			exp_s3   <= exp_s2;
			frac_s3  <= frac_s2;
			ee_s3    <= ee_s2;
			fk_s3    <= fk_c;
			dk_s3    <= dk_c;
			ipart_s3 <= ipart_s2;
			nan_s3   <= nan_c;
			tiny_s3  <= tiny_c;
			ovf32_s3 <= ovf32_c;
			ovf64_s3 <= ovf64_c;
		end
	end

	// ---------------- stage 4: pack into output register
	logic [63:0] res_c;
	kind_t       kind_c;
	logic        bad_c;
	logic [7:0]  fe_c;
	logic [5:0]  pos_c;
	logic [63:0] mag_c;
	logic signed [12:0] de_c;

	always_comb begin
		res_c  = '0;
		kind_c = KIND_INT;
		bad_c  = 1'b0;
		pos_c  = 6'd31 - {1'b0, lz_s3};
		fe_c   = '0;
		mag_c  = '0;
		de_c   = ee_s3;
		case (cls_s3)
			CLS_I2L: begin
				res_c  = {{32{iv_s3[31]}}, iv_s3};
				kind_c = KIND_LONG;
			end
			CLS_I2F: begin
				kind_c = KIND_FLOAT;
				if (!izero_s3) begin
					if (fk_s3[24])
						fe_c = 8'(8'd128 + pos_c);
					else
						fe_c = 8'(8'd127 + pos_c);
					res_c = {32'd0, sgn_s3, fe_c,
						fk_s3[24] ? fk_s3[23:1] : fk_s3[22:0]};
				end
			end
			CLS_I2D: begin
				kind_c = KIND_DOUBLE;
				if (!izero_s3)
					res_c = {sgn_s3, 11'(11'd1023 + {5'd0, pos_c}), nrm_s3[30:0], 21'd0};
			end
			CLS_I2B: res_c = {32'd0, {24{iv_s3[7]}}, iv_s3[7:0]};
			CLS_I2C: res_c = {48'd0, iv_s3[15:0]};
			CLS_I2S: res_c = {32'd0, {16{iv_s3[15]}}, iv_s3[15:0]};
			CLS_D2F: begin
				kind_c = KIND_FLOAT;
				if (exp_s3 == 11'h7ff) begin
					res_c = {32'd0, sgn_s3, 8'hff,
						(frac_s3 != 52'd0), frac_s3[50:29] | {22{1'b0}}};
					if (frac_s3 != 52'd0)
						res_c[22] = 1'b1;
					if (frac_s3 != 52'd0)
						res_c[21:0] = frac_s3[50:29];
				end else if (exp_s3 == 11'd0) begin
					res_c = {32'd0, sgn_s3, 31'd0};
				end else if (ee_s3 >= -13'sd126) begin
					if (dk_s3[24])
						de_c = ee_s3 + 13'sd1;
					if (de_c > 13'sd127)
						res_c = {32'd0, sgn_s3, 8'hff, 23'd0};
					else
						res_c = {32'd0, sgn_s3, 8'(de_c + 13'sd127),
							dk_s3[24] ? dk_s3[23:1] : dk_s3[22:0]};
				end else begin
					// subnormal or zero; a carry into bit 23 lands in the exponent
					res_c = {32'd0, sgn_s3, dk_s3[30:0]};
				end
			end
			CLS_D2I: begin
				if (nan_s3 || tiny_s3)
					res_c = '0;
				else begin
					if (ovf32_s3)
						mag_c = sgn_s3 ? 64'h8000_0000 : 64'h7fff_ffff;
					else
						mag_c = ipart_s3;
					if (sgn_s3)
						mag_c = 64'd0 - mag_c;
					res_c = {32'd0, mag_c[31:0]};
				end
			end
			CLS_D2L: begin
				kind_c = KIND_LONG;
				if (!(nan_s3 || tiny_s3)) begin
					if (ovf64_s3)
						mag_c = sgn_s3 ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
					else
						mag_c = ipart_s3;
					if (sgn_s3)
						mag_c = 64'd0 - mag_c;
					res_c = mag_c;
				end
			end
			default: bad_c = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result      <= res_c;
			result_kind <= kind_c;
			unsupported <= bad_c;
		end
	end

`ifndef SYNTHESIS
	// stalled output word must hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result))
		else $error("output word changed while stalled");
	// unsupported words carry zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported |-> result == 64'd0 && result_kind == KIND_INT)
		else $error("unsupported word not zero");
	// 32-bit kinds leave the upper half clear
	a_upper: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_INT || result_kind == KIND_FLOAT)
		|-> result[63:32] == 32'd0)
		else $error("upper half set on 32-bit kind");
	// a word accepted with the pipe moving reaches stage one
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted word lost at stage one");
`endif
endmodule
